// File: rtl/gcre_pkg.sv
package gcre_pkg;

   localparam int RING_DEPTH_DEF  = 32;
   localparam int HANDLE_BITS_DEF = 16;
   localparam int MAX_RESULTS     = 40;
   localparam int WINDOW_BITS     = 22;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [1:0] KIND_AUDIO = 2'd0;
   localparam logic [1:0] KIND_VIDEO = 2'd1;
   localparam logic [1:0] KIND_OTHER = 2'd2;

   localparam int FLAG_KEY = 2;
   localparam int FLAG_HDR = 3;

   typedef enum logic [2:0] {
      EV_CACHED   = 3'd0,
      EV_DROPPED  = 3'd1,
      EV_FULL     = 3'd2,
      EV_RELEASED = 3'd3,
      EV_DISABLED = 3'd4
   } ev_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_WRITE,
      B_HREAD,
      B_HCHK,
      B_SREAD,
      B_SCHK,
      B_DREAD,
      B_DCHK,
      B_FINAL
   } bst_type;

   typedef struct packed {
      ev_type      cls;
      logic [1:0]  kind;
      logic        key;
      logic        hdr;
      logic [31:0] time_ms;
   } job_type;

   typedef struct packed {
      logic [WINDOW_BITS-1:0] window;
      logic                   key_valid;
      logic                   full;
   } status_type;

endpackage

// File: rtl/gcre_queue.sv
module gcre_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [gcre_pkg::QUEUE_DEPTH];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign empty   = (cnt_ff == 2'd0);
   assign do_pop  = pop && !empty;
   assign do_push = push && (cnt_ff != 2'(gcre_pkg::QUEUE_DEPTH));
   assign dout    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = do_push ? ~wp_ff : wp_ff;
      rp_in  = do_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wp_ff] <= din;
      end
   end

endmodule

// File: rtl/gcre_front.sv
module gcre_front #(
   parameter int HANDLE_BITS = gcre_pkg::HANDLE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [1:0]                  req_frame_kind,
   input  logic                        req_is_keyframe,
   input  logic                        req_is_codec_header,
   input  logic [31:0]                 req_frame_time,
   input  logic [15:0]                 req_frame_handle,
   input  gcre_pkg::status_type        status,
   output logic                        pending,
   output gcre_pkg::job_type           job,
   output logic [HANDLE_BITS-1:0]      handle
);

   logic                   valid_ff, valid_in;
   gcre_pkg::job_type      job_ff, job_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [1:0]             kind;
   logic                   key, hdr;
   logic [31:0]            wide_handle;

   assign pending = valid_ff;
   assign job     = job_ff;
   assign handle  = handle_ff;

   always_comb begin
      kind        = (req_frame_kind == 2'd3) ? gcre_pkg::KIND_OTHER : req_frame_kind;
      key         = (kind == gcre_pkg::KIND_VIDEO) && req_is_keyframe;
      hdr         = (kind != gcre_pkg::KIND_OTHER) && req_is_codec_header;
      wide_handle = {16'd0, req_frame_handle};
      handle_in   = wide_handle[HANDLE_BITS-1:0];
      valid_in    = accept;
      job_in.kind    = kind;
      job_in.key     = key;
      job_in.hdr     = hdr;
      job_in.time_ms = req_frame_time;
      if (status.window == '0) begin
         job_in.cls = gcre_pkg::EV_DISABLED;
      end else if (status.full) begin
         job_in.cls = gcre_pkg::EV_FULL;
      end else if (!status.key_valid && kind == gcre_pkg::KIND_VIDEO && !key && !hdr) begin
         job_in.cls = gcre_pkg::EV_DROPPED;
      end else begin
         job_in.cls = gcre_pkg::EV_CACHED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         job_ff    <= job_in;
         handle_ff <= handle_in;
      end
   end

endmodule

// File: rtl/gcre_back.sv
module gcre_back #(
   parameter int RING_DEPTH  = gcre_pkg::RING_DEPTH_DEF,
   parameter int HANDLE_BITS = gcre_pkg::HANDLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [gcre_pkg::WINDOW_BITS-1:0]      csr_wdata,
   input  logic                                  q_empty,
   input  gcre_pkg::job_type                     q_job,
   input  logic [HANDLE_BITS-1:0]                q_handle,
   output logic                                  q_pop,
   output logic                                  active,
   output gcre_pkg::status_type                  status,
   output logic                                  rsp_valid,
   output logic [2:0]                            rsp_event_res,
   output logic [15:0]                           rsp_released_handle,
   output logic                                  rsp_last_of_run
);

   localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int NW = $clog2(gcre_pkg::MAX_RESULTS + 1);

   function automatic logic [IW-1:0] nxt(input logic [IW-1:0] p);
      nxt = (p == IW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   logic [HANDLE_BITS-1:0] mem_handle [RING_DEPTH];
   logic [3:0]             mem_flags  [RING_DEPTH];
   logic [31:0]            mem_time   [RING_DEPTH];

   gcre_pkg::bst_type      state_ff, state_in;
   gcre_pkg::job_type      job_ff, job_in;
   logic [HANDLE_BITS-1:0] jh_ff, jh_in;
   logic [IW-1:0]          head_ff, head_in, tail_ff, tail_in, p_ff, p_in;
   logic [IW-1:0]          key_ff, key_in, ck_ff, ck_in;
   logic                   kv_ff, kv_in;
   logic                   av_ff, av_in, vv_ff, vv_in;
   logic [HANDLE_BITS-1:0] ah_ff, ah_in, vh_ff, vh_in;
   logic [NW-1:0]          n_ff, n_in;
   logic [gcre_pkg::WINDOW_BITS-1:0] win_ff;
   logic                   rv_ff, rv_in, rl_ff, rl_in;
   logic [2:0]             re_ff, re_in;
   logic [15:0]            rh_ff, rh_in;

   logic [IW-1:0]          rd_addr;
   logic [HANDLE_BITS-1:0] rd_handle;
   logic [3:0]             rd_flags;
   logic [31:0]            rd_time;
   logic                   wr_en;

   logic [IW:0]            cnt;
   logic [31:0]            age, win32;
   logic                   stay, is_key;
   logic                   emit;
   logic [HANDLE_BITS-1:0] emit_h;
   logic [31:0]            emit_wide;

   always_comb begin
      if (tail_ff >= head_ff) begin
         cnt = {1'b0, tail_ff} - {1'b0, head_ff};
      end else begin
         cnt = {1'b0, tail_ff} + (IW+1)'(RING_DEPTH) - {1'b0, head_ff};
      end
      win32  = {{(32-gcre_pkg::WINDOW_BITS){1'b0}}, win_ff};
      age    = job_ff.time_ms - rd_time;
      is_key = rd_flags[gcre_pkg::FLAG_KEY] && !rd_flags[gcre_pkg::FLAG_HDR];
      stay   = ({1'b0, cnt} + (IW+2)'(2) < (IW+2)'(RING_DEPTH)) &&
               ((job_ff.kind == gcre_pkg::KIND_AUDIO) ||
                (job_ff.kind == gcre_pkg::KIND_VIDEO && age < win32));
      rd_addr = (state_ff == gcre_pkg::B_HREAD) ? head_ff : p_ff;
      wr_en   = (state_ff == gcre_pkg::B_WRITE);
      q_pop   = (state_ff == gcre_pkg::B_IDLE) && !q_empty;
      active  = (state_ff != gcre_pkg::B_IDLE);
      status.window    = win_ff;
      status.key_valid = kv_ff;
      status.full      = ({1'b0, cnt} + (IW+2)'(1) >= (IW+2)'(RING_DEPTH));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gcre_pkg::B_IDLE: begin
            if (!q_empty) begin
               state_in = (q_job.cls == gcre_pkg::EV_CACHED) ? gcre_pkg::B_WRITE
                                                             : gcre_pkg::B_FINAL;
            end
         end
         gcre_pkg::B_WRITE: state_in = gcre_pkg::B_HREAD;
         gcre_pkg::B_HREAD: begin
            state_in = (head_ff == tail_ff) ? gcre_pkg::B_FINAL : gcre_pkg::B_HCHK;
         end
         gcre_pkg::B_HCHK: begin
            if (rd_flags[gcre_pkg::FLAG_HDR]) begin
               state_in = gcre_pkg::B_HREAD;
            end else if (!kv_ff) begin
               state_in = gcre_pkg::B_FINAL;
            end else begin
               state_in = gcre_pkg::B_SREAD;
            end
         end
         gcre_pkg::B_SREAD: begin
            state_in = (p_ff == tail_ff) ? gcre_pkg::B_FINAL : gcre_pkg::B_SCHK;
         end
         gcre_pkg::B_SCHK: begin
            if (!is_key) begin
               state_in = gcre_pkg::B_SREAD;
            end else begin
               state_in = stay ? gcre_pkg::B_FINAL : gcre_pkg::B_DREAD;
            end
         end
         gcre_pkg::B_DREAD: begin
            state_in = (p_ff == key_ff) ? gcre_pkg::B_FINAL : gcre_pkg::B_DCHK;
         end
         gcre_pkg::B_DCHK:  state_in = gcre_pkg::B_DREAD;
         gcre_pkg::B_FINAL: state_in = gcre_pkg::B_IDLE;
         default:           state_in = gcre_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      job_in  = job_ff;
      jh_in   = jh_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      p_in    = p_ff;
      key_in  = key_ff;
      ck_in   = ck_ff;
      kv_in   = kv_ff;
      av_in   = av_ff;
      vv_in   = vv_ff;
      ah_in   = ah_ff;
      vh_in   = vh_ff;
      n_in    = n_ff;
      emit    = 1'b0;
      emit_h  = '0;
      rv_in   = 1'b0;
      re_in   = gcre_pkg::EV_CACHED;
      rh_in   = '0;
      rl_in   = 1'b0;
      unique case (state_ff)
         gcre_pkg::B_IDLE: begin
            if (!q_empty) begin
               job_in = q_job;
               jh_in  = q_handle;
               n_in   = '0;
            end
         end
         gcre_pkg::B_WRITE: begin
            if (job_ff.key && !job_ff.hdr && !kv_ff) begin
               kv_in = 1'b1;
               ck_in = tail_ff;
            end
            tail_in = nxt(tail_ff);
         end
         gcre_pkg::B_HCHK: begin
            if (rd_flags[gcre_pkg::FLAG_HDR]) begin
               if (rd_flags[1:0] == gcre_pkg::KIND_AUDIO) begin
                  emit   = av_ff;
                  emit_h = ah_ff;
                  av_in  = 1'b1;
                  ah_in  = rd_handle;
               end else begin
                  emit   = vv_ff;
                  emit_h = vh_ff;
                  vv_in  = 1'b1;
                  vh_in  = rd_handle;
               end
               head_in = nxt(head_ff);
            end else if (!kv_ff) begin
               if (age > win32) begin
                  emit    = 1'b1;
                  emit_h  = rd_handle;
                  head_in = nxt(head_ff);
               end
            end else begin
               p_in = nxt(ck_ff);
            end
         end
         gcre_pkg::B_SCHK: begin
            if (!is_key) begin
               p_in = nxt(p_ff);
            end else begin
               key_in = p_ff;
               p_in   = head_ff;
            end
         end
         gcre_pkg::B_DREAD: begin
            if (p_ff == key_ff) begin
               ck_in   = key_ff;
               head_in = key_ff;
            end
         end
         gcre_pkg::B_DCHK: begin
            if (rd_flags[gcre_pkg::FLAG_HDR]) begin
               if (rd_flags[1:0] == gcre_pkg::KIND_AUDIO) begin
                  emit   = av_ff;
                  emit_h = ah_ff;
                  av_in  = 1'b1;
                  ah_in  = rd_handle;
               end else begin
                  emit   = vv_ff;
                  emit_h = vh_ff;
                  vv_in  = 1'b1;
                  vh_in  = rd_handle;
               end
            end else begin
               emit   = 1'b1;
               emit_h = rd_handle;
            end
            p_in = nxt(p_ff);
         end
         gcre_pkg::B_FINAL: begin
            rv_in = 1'b1;
            re_in = job_ff.cls;
            rl_in = 1'b1;
         end
         default: begin
         end
      endcase
      emit_wide = 32'(emit_h);
      if (emit && n_ff < NW'(gcre_pkg::MAX_RESULTS - 1)) begin
         rv_in = 1'b1;
         re_in = gcre_pkg::EV_RELEASED;
         rh_in = emit_wide[15:0];
         n_in  = n_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_handle[tail_ff] <= jh_ff;
         mem_flags[tail_ff]  <= {job_ff.hdr, job_ff.key, job_ff.kind};
         mem_time[tail_ff]   <= job_ff.time_ms;
      end
      rd_handle <= mem_handle[rd_addr];
      rd_flags  <= mem_flags[rd_addr];
      rd_time   <= mem_time[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gcre_pkg::B_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         ck_ff    <= '0;
         kv_ff    <= 1'b0;
         av_ff    <= 1'b0;
         vv_ff    <= 1'b0;
         ah_ff    <= '0;
         vh_ff    <= '0;
         win_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         ck_ff    <= ck_in;
         kv_ff    <= kv_in;
         av_ff    <= av_in;
         vv_ff    <= vv_in;
         ah_ff    <= ah_in;
         vh_ff    <= vh_in;
         rv_ff    <= rv_in;
         if (csr_we) begin
            win_ff <= csr_wdata;
         end
      end
      job_ff <= job_in;
      jh_ff  <= jh_in;
      p_ff   <= p_in;
      key_ff <= key_in;
      n_ff   <= n_in;
      re_ff  <= re_in;
      rh_ff  <= rh_in;
      rl_ff  <= rl_in;
   end

   assign rsp_valid           = rv_ff;
   assign rsp_event_res       = re_ff;
   assign rsp_released_handle = rh_ff;
   assign rsp_last_of_run     = rl_ff;

endmodule

// File: rtl/gop_cache_ring_evictor_top.sv
// A frame that is not cached gives its single beat after the front register, the queue and
// the back end's idle and final states. A cached frame adds the ring write, then a read and
// a check for every ring slot that the eviction reads through the registered descriptor
// memory read port, and a read for each walk that ends at the tail or at the next keyframe.
// One frame is in flight at a time; busy falls in the cycle that carries its last beat.
// Synchronous active-high reset empties the ring and header slots and zeroes the window.
// Results cannot be stalled; each beat is valid for exactly one cycle.
module gop_cache_ring_evictor_top #(
   parameter int RING_DEPTH  = gcre_pkg::RING_DEPTH_DEF,
   parameter int HANDLE_BITS = gcre_pkg::HANDLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_frame_kind,
   input  logic        req_is_keyframe,
   input  logic        req_is_codec_header,
   input  logic [31:0] req_frame_time,
   input  logic [15:0] req_frame_handle,
   output logic        rsp_valid,
   output logic [2:0]  rsp_event_res,
   output logic [15:0] rsp_released_handle,
   output logic        rsp_last_of_run,
   input  logic        csr_we,
   input  logic [21:0] csr_wdata
);

   localparam int JW = $bits(gcre_pkg::job_type);

   gcre_pkg::status_type   status;
   gcre_pkg::job_type      f_job, q_job;
   logic [HANDLE_BITS-1:0] f_handle, q_handle;
   logic                   f_pending, q_empty, q_pop, b_active, accept;

   assign accept = start && !busy;
   assign busy   = f_pending || !q_empty || b_active;

   gcre_front #(.HANDLE_BITS(HANDLE_BITS)) u_front (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .req_frame_kind      (req_frame_kind),
      .req_is_keyframe     (req_is_keyframe),
      .req_is_codec_header (req_is_codec_header),
      .req_frame_time      (req_frame_time),
      .req_frame_handle    (req_frame_handle),
      .status              (status),
      .pending             (f_pending),
      .job                 (f_job),
      .handle              (f_handle)
   );

   gcre_queue #(.WIDTH(JW + HANDLE_BITS)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_pending),
      .din   ({f_job, f_handle}),
      .pop   (q_pop),
      .dout  ({q_job, q_handle}),
      .empty (q_empty)
   );

   gcre_back #(.RING_DEPTH(RING_DEPTH), .HANDLE_BITS(HANDLE_BITS)) u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .q_empty             (q_empty),
      .q_job               (q_job),
      .q_handle            (q_handle),
      .q_pop               (q_pop),
      .active              (b_active),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_event_res       (rsp_event_res),
      .rsp_released_handle (rsp_released_handle),
      .rsp_last_of_run     (rsp_last_of_run)
   );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int DEPTH = 32;

   typedef struct {
      gcre_pkg::ev_type ev;
      logic [15:0]      handle;
      logic             last;
   } beat_type;

   typedef struct {
      int          win;
      logic [1:0]  kind;
      logic        key;
      logic        hdr;
      logic [31:0] ts;
      logic [15:0] handle;
      int          want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_frame_kind = '0;
   logic        req_is_keyframe = 1'b0;
   logic        req_is_codec_header = 1'b0;
   logic [31:0] req_frame_time = '0;
   logic [15:0] req_frame_handle = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_event_res;
   logic [15:0] rsp_released_handle;
   logic        rsp_last_of_run;
   logic        csr_we = 1'b0;
   logic [21:0] csr_wdata = '0;

   beat_type    pending_beats[$];
   int          mismatches = 0;

   // Mirror of the cache state.
   logic [21:0] window_ms;
   logic [15:0] ring_handle[DEPTH];
   logic        ring_used[DEPTH];
   logic [3:0]  ring_flags[DEPTH];
   logic [31:0] ring_ts[DEPTH];
   logic [4:0]  head, tail, key_slot;
   logic        key_held;
   logic        ahdr_used, vhdr_used;
   logic [15:0] ahdr_handle, vhdr_handle;
   int          beats_this_frame;

   gop_cache_ring_evictor_top i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_frame_kind(req_frame_kind), .req_is_keyframe(req_is_keyframe),
      .req_is_codec_header(req_is_codec_header), .req_frame_time(req_frame_time),
      .req_frame_handle(req_frame_handle), .rsp_valid(rsp_valid),
      .rsp_event_res(rsp_event_res), .rsp_released_handle(rsp_released_handle),
      .rsp_last_of_run(rsp_last_of_run), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int ring_count();
      logic [4:0] diff;
      diff = tail - head;
      return int'(diff);
   endfunction

   task automatic push_beat(input gcre_pkg::ev_type ev, input logic [15:0] h,
                            input logic last);
      if (beats_this_frame < gcre_pkg::MAX_RESULTS) begin
         pending_beats.push_back('{ev, h, last});
         beats_this_frame++;
      end
   endtask

   task automatic note_release(input logic [15:0] h);
      if (beats_this_frame < gcre_pkg::MAX_RESULTS - 1)
         push_beat(gcre_pkg::EV_RELEASED, h, 1'b0);
   endtask

   task automatic absorb_header(input logic [4:0] p);
      if (ring_flags[p][1:0] == gcre_pkg::KIND_AUDIO) begin
         if (ahdr_used) note_release(ahdr_handle);
         ahdr_used = 1'b1;
         ahdr_handle = ring_handle[p];
      end else begin
         if (vhdr_used) note_release(vhdr_handle);
         vhdr_used = 1'b1;
         vhdr_handle = ring_handle[p];
      end
   endtask

   task automatic trim_ring(input logic [1:0] kind, input logic [31:0] ts);
      logic [4:0] p, next_key;
      logic       found;
      logic [31:0] age;
      found = 1'b0;
      next_key = '0;
      while (head != tail && ring_used[head] && ring_flags[head][gcre_pkg::FLAG_HDR]) begin
         absorb_header(head);
         ring_used[head] = 1'b0;
         head = head + 5'd1;
      end
      if (head == tail || !ring_used[head]) return;
      if (!key_held) begin
         age = ts - ring_ts[head];
         if (age > 32'(window_ms)) begin
            note_release(ring_handle[head]);
            ring_used[head] = 1'b0;
            head = head + 5'd1;
         end
         return;
      end
      p = key_slot + 5'd1;
      while (p != tail && !found) begin
         if (ring_used[p] && ring_flags[p][gcre_pkg::FLAG_KEY] &&
             !ring_flags[p][gcre_pkg::FLAG_HDR]) begin
            next_key = p;
            found = 1'b1;
         end else begin
            p = p + 5'd1;
         end
      end
      if (!found) return;
      if (ring_count() + 2 < DEPTH) begin
         if (kind == gcre_pkg::KIND_AUDIO) return;
         age = ts - ring_ts[next_key];
         if (kind == gcre_pkg::KIND_VIDEO && age < 32'(window_ms)) return;
      end
      for (p = head; p != next_key; p = p + 5'd1) begin
         if (ring_used[p]) begin
            if (ring_flags[p][gcre_pkg::FLAG_HDR]) absorb_header(p);
            else note_release(ring_handle[p]);
         end
         ring_used[p] = 1'b0;
      end
      key_slot = next_key;
      head = next_key;
   endtask

   task automatic predict_frame(input logic [1:0] kind_in, input logic key_in,
                                input logic hdr_in, input logic [31:0] ts,
                                input logic [15:0] h, output gcre_pkg::ev_type final_ev);
      logic [1:0] kind;
      logic       key, hdr;
      kind = (kind_in == 2'd3) ? gcre_pkg::KIND_OTHER : kind_in;
      key = (kind == gcre_pkg::KIND_VIDEO) && key_in;
      hdr = (kind != gcre_pkg::KIND_OTHER) && hdr_in;
      beats_this_frame = 0;
      if (window_ms == '0) final_ev = gcre_pkg::EV_DISABLED;
      else if (ring_count() + 1 >= DEPTH) final_ev = gcre_pkg::EV_FULL;
      else if (!key_held && kind == gcre_pkg::KIND_VIDEO && !key && !hdr)
         final_ev = gcre_pkg::EV_DROPPED;
      else begin
         if (key && !hdr && !key_held) begin
            key_held = 1'b1;
            key_slot = tail;
         end
         ring_handle[tail] = h;
         ring_flags[tail] = {hdr, key, kind};
         ring_ts[tail] = ts;
         ring_used[tail] = 1'b1;
         tail = tail + 5'd1;
         trim_ring(kind, ts);
         final_ev = gcre_pkg::EV_CACHED;
      end
      push_beat(final_ev, 16'd0, 1'b1);
   endtask

   // Every beat on the result port is checked against the oldest expectation.
   always @(posedge clock) begin
      beat_type exp_beat;
      if (!reset && rsp_valid) begin
         if (pending_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: ev %0d handle %h last %b",
                        rsp_event_res, rsp_released_handle, rsp_last_of_run);
         end else begin
            exp_beat = pending_beats.pop_front();
            if (rsp_event_res !== exp_beat.ev || rsp_released_handle !== exp_beat.handle ||
                rsp_last_of_run !== exp_beat.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat mismatch: expected ev %0d handle %h last %b, got %0d %h %b",
                           exp_beat.ev, exp_beat.handle, exp_beat.last,
                           rsp_event_res, rsp_released_handle, rsp_last_of_run);
            end
         end
      end
   end

   task automatic drain();
      while (pending_beats.size() != 0 || busy) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_window(input logic [21:0] value);
      drain();
      csr_we = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      window_ms = value;
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic offer_frame(input logic [1:0] kind, input logic key, input logic hdr,
                              input logic [31:0] ts, input logic [15:0] h,
                              output gcre_pkg::ev_type final_ev);
      req_frame_kind = kind;
      req_is_keyframe = key;
      req_is_codec_header = hdr;
      req_frame_time = ts;
      req_frame_handle = h;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_frame(kind, key, hdr, ts, h, final_ev);
      @(negedge clock);
   endtask

   task automatic idle_sender(input bit allow);
      int pick, gap;
      pick = $urandom_range(0, 9);
      gap = 0;
      if (allow && pick >= 6) gap = (pick == 9) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   row_type          rows[$];
   int               windows[4];
   int               steps[4];
   logic [31:0]      now_ms;
   gcre_pkg::ev_type got_ev;
   int               pick;
   logic [1:0]       kind;
   logic             key, hdr;

   initial begin
      window_ms = '0;
      head = '0;
      tail = '0;
      key_slot = '0;
      key_held = 1'b0;
      ahdr_used = 1'b0;
      vhdr_used = 1'b0;
      ahdr_handle = '0;
      vhdr_handle = '0;
      foreach (ring_used[i]) begin
         ring_used[i] = 1'b0;
         ring_handle[i] = '0;
         ring_flags[i] = '0;
         ring_ts[i] = '0;
      end

      rows = '{
         '{-1, gcre_pkg::KIND_VIDEO, 1'b1, 1'b0, 32'h0000_0000, 16'hFFFF,
           int'(gcre_pkg::EV_DISABLED)},
         '{-1, gcre_pkg::KIND_AUDIO, 1'b0, 1'b1, 32'hFFFF_FFFF, 16'h0000,
           int'(gcre_pkg::EV_DISABLED)},
         '{1000, gcre_pkg::KIND_VIDEO, 1'b0, 1'b0, 32'd5, 16'h0001,
           int'(gcre_pkg::EV_DROPPED)},
         '{-1, gcre_pkg::KIND_AUDIO, 1'b0, 1'b1, 32'd6, 16'h00A1,
           int'(gcre_pkg::EV_CACHED)},
         '{-1, gcre_pkg::KIND_VIDEO, 1'b0, 1'b1, 32'd7, 16'h00B1,
           int'(gcre_pkg::EV_CACHED)},
         '{-1, gcre_pkg::KIND_AUDIO, 1'b0, 1'b0, 32'd8, 16'h0010, -1},
         '{-1, gcre_pkg::KIND_VIDEO, 1'b1, 1'b0, 32'd10, 16'h0011, -1},
         '{-1, gcre_pkg::KIND_VIDEO, 1'b0, 1'b0, 32'd20, 16'h0012, -1},
         '{-1, gcre_pkg::KIND_AUDIO, 1'b0, 1'b1, 32'd21, 16'h00A2, -1},
         '{-1, gcre_pkg::KIND_OTHER, 1'b1, 1'b1, 32'd30, 16'h0013, -1},
         '{-1, 2'd3, 1'b1, 1'b1, 32'd40, 16'h0014, -1},
         '{-1, gcre_pkg::KIND_VIDEO, 1'b1, 1'b0, 32'd2000, 16'h0015, -1},
         '{-1, gcre_pkg::KIND_VIDEO, 1'b0, 1'b1, 32'd2001, 16'h00B2, -1},
         '{-1, gcre_pkg::KIND_VIDEO, 1'b1, 1'b0, 32'd2500, 16'h0016, -1},
         '{-1, gcre_pkg::KIND_AUDIO, 1'b0, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, -1},
         '{-1, gcre_pkg::KIND_VIDEO, 1'b1, 1'b0, 32'h0000_0000, 16'h5A5A, -1},
         '{1, gcre_pkg::KIND_VIDEO, 1'b0, 1'b0, 32'd1, 16'hA5A5, -1},
         '{-1, gcre_pkg::KIND_VIDEO, 1'b1, 1'b0, 32'd3, 16'h0017, -1},
         '{-1, gcre_pkg::KIND_AUDIO, 1'b0, 1'b0, 32'd9, 16'h0018, -1},
         '{-1, gcre_pkg::KIND_OTHER, 1'b0, 1'b0, 32'd9, 16'h0019, -1}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (rows[i]) begin
         if (rows[i].win >= 0) begin
            start = 1'b0;
            set_window(22'(rows[i].win));
         end
         offer_frame(rows[i].kind, rows[i].key, rows[i].hdr, rows[i].ts, rows[i].handle,
                     got_ev);
         if (rows[i].want >= 0 && int'(got_ev) != rows[i].want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("row %0d: expected final ev %0d, model gives %0d",
                        i, rows[i].want, got_ev);
         end
         idle_sender(1'b1);
      end

      windows = '{3600000, 500, 0, 4194303};
      windows[1 + 1] = int'($urandom_range(2, 3600000));
      steps = '{20, 120, 0, 60};
      steps[2] = int'($urandom_range(1, 2000));
      now_ms = $urandom;
      for (int ph = 0; ph < 4; ph++) begin
         start = 1'b0;
         set_window(22'(windows[ph]));
         for (int n = 0; n < 63; n++) begin
            pick = int'($urandom_range(0, 99));
            key = 1'b0;
            hdr = 1'b0;
            if (pick < 8) begin
               kind = gcre_pkg::KIND_AUDIO;
               hdr = 1'b1;
            end else if (pick < 14) begin
               kind = gcre_pkg::KIND_VIDEO;
               hdr = 1'b1;
            end else if (pick < 30) begin
               kind = gcre_pkg::KIND_AUDIO;
            end else if (pick < 38) begin
               kind = (pick < 34) ? gcre_pkg::KIND_OTHER : 2'd3;
               key = 1'($urandom_range(0, 1));
               hdr = 1'($urandom_range(0, 1));
            end else begin
               kind = gcre_pkg::KIND_VIDEO;
               key = ($urandom_range(0, 7) == 0);
               if ($urandom_range(0, 19) == 0) hdr = 1'b1;
            end
            if ($urandom_range(0, 19) == 0) now_ms = $urandom;
            else now_ms = now_ms + $urandom_range(0, steps[ph]);
            offer_frame(kind, key, hdr, now_ms, 16'($urandom), got_ev);
            idle_sender(n >= 20);
         end
      end
      start = 1'b0;

      while (pending_beats.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (mismatches == 0 && pending_beats.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
